// File: rtl/ctcu_pkg.sv
// ----------------------------------------------------------------------------
// Columnar transposition unit package
// Shared constants, register indexes and the control/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package ctcu_pkg;

	localparam int MAX_COLUMNS_DEF = 8;
	localparam int MAX_ROWS_DEF    = 8;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;
	localparam int COUNT_W     = 4;
	localparam int CMP_W       = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 2'd2;

	localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 4'd5;
	localparam logic [COUNT_W-1:0] ROW_COUNT_RST    = 4'd3;
	localparam logic               DECRYPT_MODE_RST = 1'b0;

	localparam logic [7:0] PAD_BYTE = 8'h20;

	typedef struct packed {
		logic               wr;
		logic               clr_fill;
		logic               rd;
		logic               pos_load;
		logic [COUNT_W-1:0] pos_base;
		logic               blk_last;
		logic               msg_last;
	} cmd_t;

	typedef struct packed {
		logic               full;
		logic               decrypt;
		logic               slot_free;
		logic [COUNT_W-1:0] inner_len;
		logic [COUNT_W-1:0] outer_len;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/ctcu_ctrl.sv
// ----------------------------------------------------------------------------
// Columnar transposition unit controller
// Sequences block fill and the column or row readout of a full or final block.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          end_of_message,
	input  wire ctcu_pkg::stat_t stat,
	output ctcu_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_FILL = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [ctcu_pkg::COUNT_W-1:0]    inner_q;
	logic [ctcu_pkg::COUNT_W-1:0]    inner_d;
	logic [ctcu_pkg::COUNT_W-1:0]    outer_q;
	logic [ctcu_pkg::COUNT_W-1:0]    outer_d;
	logic                            last_q;
	logic                            last_d;
	logic                            accept;
	logic                            inner_end;
	logic                            outer_end;

	assign in_ready  = (state_q == ST_FILL);
	assign accept    = in_valid && in_ready;
	assign inner_end = (inner_q == ctcu_pkg::COUNT_W'(stat.inner_len - 4'd1));
	assign outer_end = (outer_q == ctcu_pkg::COUNT_W'(stat.outer_len - 4'd1));

	always_comb begin
		state_d = state_q;
		inner_d = inner_q;
		outer_d = outer_q;
		last_d  = last_q;
		cmd     = '0;
		unique case (state_q)
			ST_FILL: begin
				if (accept) begin
					cmd.wr = 1'b1;
					if (stat.full || end_of_message) begin
						if (stat.decrypt && !stat.full) begin
							cmd.clr_fill = 1'b1;
						end else begin
							state_d      = ST_EMIT;
							last_d       = end_of_message;
							inner_d      = '0;
							outer_d      = '0;
							cmd.pos_load = 1'b1;
							cmd.pos_base = '0;
						end
					end
				end
			end
			ST_EMIT: begin
				if (stat.slot_free) begin
					cmd.rd       = 1'b1;
					cmd.blk_last = inner_end && outer_end;
					cmd.msg_last = inner_end && outer_end && last_q;
					if (inner_end) begin
						inner_d = '0;
						if (outer_end) begin
							state_d      = ST_FILL;
							cmd.clr_fill = 1'b1;
						end else begin
							outer_d      = ctcu_pkg::COUNT_W'(outer_q + 4'd1);
							cmd.pos_load = 1'b1;
							cmd.pos_base = ctcu_pkg::COUNT_W'(outer_q + 4'd1);
						end
					end else begin
						inner_d = ctcu_pkg::COUNT_W'(inner_q + 4'd1);
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			inner_q <= '0;
			outer_q <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			inner_q <= inner_d;
			outer_q <= outer_d;
			last_q  <= last_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ctcu_dpath.sv
// ----------------------------------------------------------------------------
// Columnar transposition unit datapath
// Configuration registers, block buffer, fill count, read pointer and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcu_dpath #(
	parameter int MAX_COLUMNS = ctcu_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = ctcu_pkg::MAX_ROWS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [ctcu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ctcu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [7:0]                       data_byte,
	input  wire ctcu_pkg::cmd_t                   cmd,
	output ctcu_pkg::stat_t                       stat,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            out_byte,
	output logic                                  block_last,
	output logic                                  message_last
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int CW    = ctcu_pkg::COUNT_W;
	localparam int XW    = ctcu_pkg::CMP_W;

	logic [CW-1:0] column_count_q;
	logic [CW-1:0] row_count_q;
	logic          decrypt_q;
	logic [CW-1:0] cols;
	logic [CW-1:0] rows;
	logic [7:0]    size;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] pos_q;
	logic [7:0]    mem [DEPTH];
	logic          out_valid_q;
	logic [7:0]    raw_q;
	logic          pad_q;
	logic          zmap_q;
	logic          blk_q;
	logic          msg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= ctcu_pkg::COLUMN_COUNT_RST;
			row_count_q    <= ctcu_pkg::ROW_COUNT_RST;
			decrypt_q      <= ctcu_pkg::DECRYPT_MODE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ctcu_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
				ctcu_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data;
				ctcu_pkg::REG_DECRYPT_MODE: decrypt_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (column_count_q == '0) begin
			cols = CW'(1);
		end else if ({1'b0, column_count_q} > (CW + 1)'(MAX_COLUMNS)) begin
			cols = CW'(MAX_COLUMNS);
		end else begin
			cols = column_count_q;
		end
		if (row_count_q == '0) begin
			rows = CW'(1);
		end else if ({1'b0, row_count_q} > (CW + 1)'(MAX_ROWS)) begin
			rows = CW'(MAX_ROWS);
		end else begin
			rows = row_count_q;
		end
	end

	assign size = 8'(cols * rows);

	assign stat.full      = ((XW'(fill_q) + XW'(1)) >= XW'(size));
	assign stat.decrypt   = decrypt_q;
	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.inner_len = decrypt_q ? cols : rows;
	assign stat.outer_len = decrypt_q ? rows : cols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.clr_fill) begin
			fill_q <= '0;
		end else if (cmd.wr) begin
			fill_q <= FW'(fill_q + FW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_load) begin
			pos_q <= AW'(cmd.pos_base);
		end else if (cmd.rd) begin
			pos_q <= AW'(XW'(pos_q) + XW'(stat.outer_len));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && (XW'(fill_q) < XW'(DEPTH))) begin
			mem[fill_q[AW-1:0]] <= data_byte;
		end
		if (cmd.rd) begin
			raw_q  <= mem[pos_q];
			pad_q  <= !decrypt_q && (XW'(pos_q) >= XW'(fill_q));
			zmap_q <= !decrypt_q;
			blk_q  <= cmd.blk_last;
			msg_q  <= cmd.msg_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = (pad_q || (zmap_q && (raw_q == 8'd0))) ? ctcu_pkg::PAD_BYTE : raw_q;
	assign block_last   = blk_q;
	assign message_last = msg_q;

endmodule

`default_nettype wire

// File: rtl/block_columnar_transposition_unit.sv
// ----------------------------------------------------------------------------
// Block columnar transposition unit
// Top level: controller and datapath of the block transposition cipher.
// ----------------------------------------------------------------------------
// Message bytes enter on the input channel (in_valid/in_ready) with
// end_of_message on the final byte, one transfer per cycle while the block
// buffer fills. When the buffer holds column_count*row_count bytes, or the
// flagged byte arrives, input stops and the block is read out on the output
// channel (out_valid/out_ready), one byte per cycle while the receiver is
// ready, column by column when encrypting and in the inverse order when
// decrypting. The first output byte is valid once the controller has entered
// the readout state and the byte has been read into the output register.
// The single block buffer is not double buffered, so filling and readout
// take turns.
// A partial final block is padded with spaces when encrypting and dropped
// when decrypting. Configuration is written through cfg_write, cfg_index
// and cfg_data while the unit is idle. Reset clears the fill count and the
// output valid flag and restores the register defaults (five columns, three
// rows, encrypt). A stalled receiver holds the output byte and pauses the
// readout; the final byte of a block may wait while new input is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module block_columnar_transposition_unit #(
	parameter int MAX_COLUMNS = ctcu_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = ctcu_pkg::MAX_ROWS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [ctcu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ctcu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             end_of_message,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            out_byte,
	output logic                                  block_last,
	output logic                                  message_last
);

	ctcu_pkg::cmd_t  cmd;
	ctcu_pkg::stat_t stat;

	ctcu_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.end_of_message (end_of_message),
		.stat           (stat),
		.cmd            (cmd)
	);

	ctcu_dpath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (data_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.block_last   (block_last),
		.message_last (message_last)
	);

endmodule

`default_nettype wire

// File: rtl/ctcu_checker.sv
// ----------------------------------------------------------------------------
// Columnar transposition unit checker
// Port-level assertions on the transposition unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       block_last,
	input wire logic       message_last
);

	// A waiting output transfer keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the transfer");

	// A waiting output transfer keeps its byte.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte))
		else $error("out_byte changed while stalled");

	// Input is closed while a block is still being read out.
	a_no_input_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_last |-> !in_ready)
		else $error("input open in the middle of a block readout");

	// The end of a message is always the end of a block.
	a_msg_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_last |-> block_last)
		else $error("message_last without block_last");

endmodule

bind block_columnar_transposition_unit ctcu_checker u_ctcu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.block_last   (block_last),
	.message_last (message_last)
);

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Columnar transposition unit testbench
// Feeds message bytes through the unit with random idle bursts on both
// channels and checks every output byte against a behavioral predictor.
// It covers encrypt and decrypt, padding and dropped partial blocks,
// clamped counts, geometry changes mid-block and heavy output backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ctcu_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STORE_DEPTH  = ctcu_pkg::MAX_COLUMNS_DEF * ctcu_pkg::MAX_ROWS_DEF;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 3000;

	typedef struct packed {
		logic [7:0] value;
		logic       blk_end;
		logic       msg_end;
	} cipher_byte_t;

	logic                             clk            = 1'b0;
	logic                             arst_n         = 1'b0;
	logic                             cfg_write      = 1'b0;
	logic [ctcu_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
	logic [ctcu_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;
	logic                             in_valid       = 1'b0;
	logic                             in_ready;
	logic [7:0]                       data_byte      = 8'h00;
	logic                             end_of_message = 1'b0;
	logic                             out_valid;
	logic                             out_ready      = 1'b0;
	logic [7:0]                       out_byte;
	logic                             block_last;
	logic                             message_last;

	cipher_byte_t pending_bytes[$];
	logic [7:0]   cipher_store[STORE_DEPTH];
	int           fill_level;
	logic [3:0]   col_setting;
	logic [3:0]   row_setting;
	logic         decrypt_setting;

	int  error_count  = 0;
	int  sent_count   = 0;
	int  idle_cycles  = 0;
	int  hold_cycles  = 0;
	int  stall_left   = 0;
	bit  quiet        = 1'b0;
	bit  calm         = 1'b0;

	block_columnar_transposition_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.block_last     (block_last),
		.message_last   (message_last)
	);

	always #5 clk = ~clk;

	function automatic int effective_count(input logic [3:0] setting, input int limit);
		if (setting == 4'd0)
			return 1;
		if (int'(setting) > limit)
			return limit;
		return int'(setting);
	endfunction

	function automatic logic [7:0] random_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [3:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 4'd0;
		if (r == 1)
			return 4'($urandom_range(8, 15));
		return 4'($urandom_range(1, 4));
	endfunction

	// Advances the predictor by one accepted byte and queues any block it completes.
	task automatic transpose_byte(input logic [7:0] value, input logic eom);
		int cols;
		int rows;
		int blk_size;
		int pos;
		int k;
		cipher_byte_t item;
		cols = effective_count(col_setting, ctcu_pkg::MAX_COLUMNS_DEF);
		rows = effective_count(row_setting, ctcu_pkg::MAX_ROWS_DEF);
		blk_size = cols * rows;
		if (fill_level < STORE_DEPTH)
			cipher_store[fill_level] = value;
		fill_level++;
		if (fill_level < blk_size && !eom)
			return;
		if (fill_level < blk_size && decrypt_setting) begin
			fill_level = 0;
			return;
		end
		k = 0;
		for (int a = 0; a < (decrypt_setting ? rows : cols); a++) begin
			for (int b = 0; b < (decrypt_setting ? cols : rows); b++) begin
				if (decrypt_setting) begin
					pos = a + rows * b;
					item.value = cipher_store[pos];
				end else begin
					pos = b * cols + a;
					item.value = ctcu_pkg::PAD_BYTE;
					if (pos < fill_level && pos < STORE_DEPTH && cipher_store[pos] != 8'h00)
						item.value = cipher_store[pos];
				end
				item.blk_end = (k == blk_size - 1);
				item.msg_end = (k == blk_size - 1) && eom;
				pending_bytes.push_back(item);
				k++;
			end
		end
		fill_level = 0;
	endtask

	task automatic send_byte(input logic [7:0] value, input logic eom);
		int gap;
		if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = value;
		end_of_message = eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		transpose_byte(value, eom);
		sent_count++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [ctcu_pkg::CFG_INDEX_W-1:0] idx,
			input logic [ctcu_pkg::CFG_DATA_W-1:0] value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			ctcu_pkg::REG_COLUMN_COUNT: col_setting = value;
			ctcu_pkg::REG_ROW_COUNT:    row_setting = value;
			ctcu_pkg::REG_DECRYPT_MODE: decrypt_setting = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [3:0] cols, input logic [3:0] rows, input logic mode);
		write_register(ctcu_pkg::REG_COLUMN_COUNT, cols);
		write_register(ctcu_pkg::REG_ROW_COUNT, rows);
		write_register(ctcu_pkg::REG_DECRYPT_MODE, {3'($urandom_range(0, 7)), mode});
	endtask

	task automatic test_reset_geometry();
		// Five by three encrypt after reset; a short message gets padded.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_drained();
	endtask

	task automatic test_clamped_counts();
		// Zero columns act as one, so the flagged byte fills the block.
		configure(4'd0, 4'd2, 1'b0);
		write_register(REG_UNUSED, 4'hF);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		wait_drained();
		configure(4'd15, 4'd0, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b1);
		wait_drained();
	endtask

	task automatic test_decrypt_blocks();
		// Zero bytes pass through; the partial tail block is dropped.
		configure(4'd2, 4'd2, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h33, 1'b1);
		wait_drained();
	endtask

	task automatic test_geometry_change();
		// Shrinking the block below the held count emits it on the next byte.
		configure(4'd3, 4'd3, 1'b0);
		for (int i = 0; i < 5; i++)
			send_byte(random_byte(), 1'b0);
		wait_drained();
		configure(4'd2, 4'd2, 1'b0);
		send_byte(random_byte(), 1'b0);
		send_byte(random_byte(), 1'b1);
		wait_drained();
	endtask

	task automatic test_receiver_hold();
		configure(4'd4, 4'd4, 1'b0);
		hold_cycles = 150;
		for (int i = 0; i < 36; i++)
			send_byte(random_byte(), i == 35);
		wait_drained();
	endtask

	task automatic test_random_messages();
		int target;
		int blk_size;
		int msg_len;
		logic [3:0] cols;
		logic [3:0] rows;
		logic mode;
		bit first;
		target = sent_count + 150;
		first = 1'b1;
		while (sent_count < target) begin
			wait_drained();
			if (first) begin
				cols = 4'd15;
				rows = 4'd9;
				mode = 1'b0;
			end else begin
				cols = pick_count();
				rows = pick_count();
				mode = 1'($urandom_range(0, 1));
			end
			configure(cols, rows, mode);
			blk_size = effective_count(cols, ctcu_pkg::MAX_COLUMNS_DEF) *
				effective_count(rows, ctcu_pkg::MAX_ROWS_DEF);
			if (first)
				msg_len = 5;
			else if (blk_size > 16)
				msg_len = mode ? blk_size : $urandom_range(1, 6);
			else if (mode && $urandom_range(0, 3) != 0)
				msg_len = blk_size * $urandom_range(1, 2);
			else
				msg_len = $urandom_range(1, 2 * blk_size + 1);
			first = 1'b0;
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < msg_len; i++)
				send_byte(random_byte(), i == msg_len - 1);
		end
		calm = 1'b0;
		wait_drained();
	endtask

	task automatic test_streaming();
		quiet = 1'b1;
		configure(4'd3, 4'd2, 1'b0);
		for (int i = 0; i < 30; i++)
			send_byte(random_byte(), i == 29);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready = 1'b0;
			hold_cycles--;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(1, 8) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cipher_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected output byte %02h blk %0b msg %0b",
						out_byte, block_last, message_last);
			end else begin
				want = pending_bytes.pop_front();
				if (want.value !== out_byte || want.blk_end !== block_last ||
						want.msg_end !== message_last) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected %02h blk %0b msg %0b, got %02h blk %0b msg %0b",
							want.value, want.blk_end, want.msg_end,
							out_byte, block_last, message_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		fill_level = 0;
		col_setting = ctcu_pkg::COLUMN_COUNT_RST;
		row_setting = ctcu_pkg::ROW_COUNT_RST;
		decrypt_setting = ctcu_pkg::DECRYPT_MODE_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_geometry();
		test_clamped_counts();
		test_decrypt_blocks();
		test_geometry_change();
		test_receiver_hold();
		test_random_messages();
		test_streaming();
		wait_drained();
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
